@@ rtl/dcrl_pkg.sv @@
// ----------------------------------------------------------------------------
// dcrl_pkg
// Shared types, register codes and reset values for the drive ramp limiter.
// ----------------------------------------------------------------------------
package dcrl_pkg;

    localparam int STICK_W   = 16;
    localparam int REG_W     = 15;
    localparam int ELAPSED_W = 16;
    localparam int IDX_W     = 2;
    localparam int PROD_W    = ELAPSED_W + REG_W;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 40;

    typedef logic signed [STICK_W-1:0] q15_t;
    typedef logic [REG_W-1:0]          cfg_val_t;

    typedef enum logic {
        OP_TANK   = 1'b0,
        OP_ARCADE = 1'b1
    } op_t;

    typedef enum logic [IDX_W-1:0] {
        CFG_DEAD_BAND   = 2'd0,
        CFG_MATCH_BAND  = 2'd1,
        CFG_RAMP_PER_MS = 2'd2,
        CFG_MAX_STEP    = 2'd3
    } cfg_idx_t;

    localparam cfg_val_t DEAD_BAND_RST   = 15'd3277;
    localparam cfg_val_t MATCH_BAND_RST  = 15'd1638;
    localparam cfg_val_t RAMP_PER_MS_RST = 15'd33;
    localparam cfg_val_t MAX_STEP_RST    = 15'd8192;

    // Pipeline control handed to each lane.
    typedef struct packed {
        logic load1;   // item accepted into the conditioning stage
        logic load2;   // conditioned item moves into the ramp stage
        logic fine;    // fine mode in force for the item being accepted
        op_t  op;      // pair that the ramp stage item updates
    } lane_ctrl_t;

endpackage

@@ rtl/dual_channel_drive_ramp_limiter.sv @@
// ----------------------------------------------------------------------------
// dual_channel_drive_ramp_limiter
// Two-channel drive command slew limiter with dead band and fine mode.
// ----------------------------------------------------------------------------
// Accepts one item per clock while the result side is ready, and returns one
// result item per input item, in order. The path is two stages: the first
// conditions both sticks (tank match, fine-mode halving, dead band) and forms
// the step limit with one 16x15 multiply; the second ramps the stored speeds
// of both lanes and loads the output register. Back-pressure can hold an item
// in stage 1; the speed registers close their loop in the second stage, so
// each item ramps from the speeds left by the item before it. Configuration
// writes are registered and should be made with no item in flight.
module dual_channel_drive_ramp_limiter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [15:0] first_stick, [31:16] second_stick, [47:32] elapsed_ms,
    // [48] back_pressed, [55:49] zero
    input  logic [dcrl_pkg::IN_DATA_W-1:0]       s_tdata,
    // [0] operation
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [15:0] first_drive, [31:16] second_drive, [32] fine_mode, [39:33] zero
    output logic [dcrl_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                 cfg_we,
    input  logic [dcrl_pkg::IDX_W-1:0]           cfg_index,
    input  logic [dcrl_pkg::REG_W-1:0]           cfg_data
);

    dcrl_pkg::cfg_val_t   dead_band_reg;
    dcrl_pkg::cfg_val_t   match_band_reg;
    dcrl_pkg::cfg_val_t   ramp_per_ms_reg;
    dcrl_pkg::cfg_val_t   max_step_reg;

    logic                 s_acc;
    dcrl_pkg::op_t        op_in;
    dcrl_pkg::q15_t       first_stick;
    dcrl_pkg::q15_t       second_stick;
    dcrl_pkg::q15_t       lane0_stick;
    logic [15:0]          elapsed_ms;
    logic                 back_pressed;
    logic signed [16:0]   diff;
    logic [16:0]          diff_mag;
    logic                 match_hit;

    logic                 fine_reg;
    logic                 fine_next;
    logic                 v1_reg;
    logic                 v1_next;
    dcrl_pkg::op_t        op1_reg;
    logic                 fine1_reg;

    logic                 take;
    logic                 load2;
    dcrl_pkg::cfg_val_t   step;
    dcrl_pkg::lane_ctrl_t lane_ctrl;
    dcrl_pkg::q15_t       speed_a;
    dcrl_pkg::q15_t       speed_b;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_band_reg   <= dcrl_pkg::DEAD_BAND_RST;
            match_band_reg  <= dcrl_pkg::MATCH_BAND_RST;
            ramp_per_ms_reg <= dcrl_pkg::RAMP_PER_MS_RST;
            max_step_reg    <= dcrl_pkg::MAX_STEP_RST;
        end else if (cfg_we) begin
            case (dcrl_pkg::cfg_idx_t'(cfg_index))
                dcrl_pkg::CFG_DEAD_BAND:   dead_band_reg   <= cfg_data;
                dcrl_pkg::CFG_MATCH_BAND:  match_band_reg  <= cfg_data;
                dcrl_pkg::CFG_RAMP_PER_MS: ramp_per_ms_reg <= cfg_data;
                dcrl_pkg::CFG_MAX_STEP:    max_step_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input unpacking and tank stick matching
    assign s_acc        = s_tvalid && s_tready;
    assign op_in        = dcrl_pkg::op_t'(s_tuser);
    assign first_stick  = s_tdata[15:0];
    assign second_stick = s_tdata[31:16];
    assign elapsed_ms   = s_tdata[47:32];
    assign back_pressed = s_tdata[48];

    always_comb begin
        diff      = {first_stick[15], first_stick} - {second_stick[15], second_stick};
        diff_mag  = diff[16] ? 17'(-diff) : 17'(diff);
        match_hit = (op_in == dcrl_pkg::OP_TANK) && (diff_mag < {2'b00, match_band_reg});
        lane0_stick = match_hit ? second_stick : first_stick;
    end

    // Fine mode toggles when an item with back_pressed set is accepted, before that item is shaped.
    assign fine_next = fine_reg ^ back_pressed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fine_reg <= 1'b0;
        end else if (s_acc) begin
            fine_reg <= fine_next;
        end
    end

    // Stage 1 occupancy
    assign load2    = v1_reg && take;
    assign s_tready = !v1_reg || take;

    always_comb begin
        if (s_acc) begin
            v1_next = 1'b1;
        end else if (load2) begin
            v1_next = 1'b0;
        end else begin
            v1_next = v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op1_reg   <= op_in;
            fine1_reg <= fine_next;
        end
    end

    assign lane_ctrl = '{load1: s_acc, load2: load2, fine: fine_next, op: op1_reg};

    dcrl_step u_step (
        .aclk        (aclk),
        .load        (s_acc),
        .elapsed_ms  (elapsed_ms),
        .ramp_per_ms (ramp_per_ms_reg),
        .max_step    (max_step_reg),
        .step        (step)
    );

    // Lane A: left / move. Lane B: right / rotate.
    dcrl_lane u_lane_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (lane_ctrl),
        .stick     (lane0_stick),
        .dead_band (dead_band_reg),
        .step      (step),
        .speed_new (speed_a)
    );

    dcrl_lane u_lane_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (lane_ctrl),
        .stick     (second_stick),
        .dead_band (dead_band_reg),
        .step      (step),
        .speed_new (speed_b)
    );

    dcrl_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load2),
        .op       (op1_reg),
        .fine     (fine1_reg),
        .speed_a  (speed_a),
        .speed_b  (speed_b),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A conditioned item waits in stage 1 until the ramp stage takes it.
    a_stage1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !load2) |=> v1_reg)
        else $error("stage 1 item dropped");

    // Fine mode changes only when an item is accepted.
    a_fine_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_acc |=> $stable(fine_reg))
        else $error("fine mode changed without an item");

    // First drive is always negated with saturation.
    a_first_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] != 16'h8000))
        else $error("first drive holds the most negative code");

    // Results never appear without an item in stage 1 the cycle before.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && !v1_reg) |=> !m_tvalid)
        else $error("result without a source item");

endmodule

@@ rtl/dcrl_step.sv @@
// ----------------------------------------------------------------------------
// dcrl_step
// Allowed speed change for one update: elapsed time times rate, capped.
// ----------------------------------------------------------------------------
module dcrl_step (
    input  logic                              aclk,
    input  logic                              load,
    input  logic [dcrl_pkg::ELAPSED_W-1:0]    elapsed_ms,
    input  dcrl_pkg::cfg_val_t                ramp_per_ms,
    input  dcrl_pkg::cfg_val_t                max_step,
    output dcrl_pkg::cfg_val_t                step
);

    logic [dcrl_pkg::PROD_W-1:0] prod;
    dcrl_pkg::cfg_val_t          step_next;
    dcrl_pkg::cfg_val_t          step_reg;

    // Full-width product, so large elapsed times saturate at the cap.
    assign prod = elapsed_ms * {{dcrl_pkg::ELAPSED_W{1'b0}}, ramp_per_ms};

    always_comb begin
        if (prod > {{dcrl_pkg::ELAPSED_W{1'b0}}, max_step}) begin
            step_next = max_step;
        end else begin
            step_next = prod[dcrl_pkg::REG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            step_reg <= step_next;
        end
    end

    assign step = step_reg;

endmodule

@@ rtl/dcrl_lane.sv @@
// ----------------------------------------------------------------------------
// dcrl_lane
// One channel: fine-mode halving and dead band, then the slew-limited speed
// for the tank and the arcade pair member that this lane owns.
// ----------------------------------------------------------------------------
module dcrl_lane (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dcrl_pkg::lane_ctrl_t  ctrl,
    input  dcrl_pkg::q15_t        stick,
    input  dcrl_pkg::cfg_val_t    dead_band,
    input  dcrl_pkg::cfg_val_t    step,
    output dcrl_pkg::q15_t        speed_new
);

    logic signed [16:0] stick_ext;
    logic signed [16:0] half;
    logic signed [16:0] shaped;
    logic [16:0]        shaped_mag;
    dcrl_pkg::q15_t     target_next;
    dcrl_pkg::q15_t     target_reg;

    dcrl_pkg::q15_t     tank_speed_reg;
    dcrl_pkg::q15_t     arcade_speed_reg;
    dcrl_pkg::q15_t     cur;
    logic signed [17:0] cur_ext;
    logic signed [17:0] tgt_ext;
    logic signed [17:0] step_ext;
    logic signed [17:0] moved;

    // Conditioning stage: halve toward zero, then dead band.
    always_comb begin
        stick_ext = {stick[15], stick};
        half      = (stick_ext + $signed({16'd0, stick[15]})) >>> 1;
        shaped    = ctrl.fine ? half : stick_ext;
        shaped_mag = shaped[16] ? 17'(-shaped) : 17'(shaped);
        if (shaped_mag < {2'b00, dead_band}) begin
            target_next = '0;
        end else begin
            target_next = shaped[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load1) begin
            target_reg <= target_next;
        end
    end

    // Ramp stage: move toward target by at most step, never past it.
    always_comb begin
        cur      = (ctrl.op == dcrl_pkg::OP_ARCADE) ? arcade_speed_reg : tank_speed_reg;
        cur_ext  = {{2{cur[15]}}, cur};
        tgt_ext  = {{2{target_reg[15]}}, target_reg};
        step_ext = {3'b000, step};
        if (tgt_ext < cur_ext) begin
            moved = cur_ext - step_ext;
            if (moved < tgt_ext) begin
                moved = tgt_ext;
            end
        end else begin
            moved = cur_ext + step_ext;
            if (moved > tgt_ext) begin
                moved = tgt_ext;
            end
        end
        speed_new = moved[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tank_speed_reg   <= '0;
            arcade_speed_reg <= '0;
        end else if (ctrl.load2) begin
            if (ctrl.op == dcrl_pkg::OP_ARCADE) begin
                arcade_speed_reg <= speed_new;
            end else begin
                tank_speed_reg <= speed_new;
            end
        end
    end

endmodule

@@ rtl/dcrl_merge.sv @@
// ----------------------------------------------------------------------------
// dcrl_merge
// Combines both lanes into the result item and holds it for the sink.
// ----------------------------------------------------------------------------
module dcrl_merge (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 load,
    input  dcrl_pkg::op_t                        op,
    input  logic                                 fine,
    input  dcrl_pkg::q15_t                       speed_a,
    input  dcrl_pkg::q15_t                       speed_b,
    output logic                                 take,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [dcrl_pkg::OUT_DATA_W-1:0]      m_tdata
);

    logic                              valid_reg;
    logic                              valid_next;
    logic [dcrl_pkg::OUT_DATA_W-1:0]   data_reg;
    logic [dcrl_pkg::OUT_DATA_W-1:0]   data_next;
    dcrl_pkg::q15_t                    first_drive;
    dcrl_pkg::q15_t                    second_drive;

    // Negate, saturating the most negative code.
    function automatic dcrl_pkg::q15_t neg_sat(input dcrl_pkg::q15_t v);
        if (v == 16'sh8000) begin
            return 16'sh7FFF;
        end
        return -v;
    endfunction

    always_comb begin
        first_drive  = neg_sat(speed_a);
        second_drive = (op == dcrl_pkg::OP_TANK) ? neg_sat(speed_b) : speed_b;
        data_next    = {7'd0, fine, second_drive, first_drive};
    end

    assign take = !valid_reg || m_tready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

@@ tb/sv/dual_channel_drive_ramp_limiter_tb.sv @@
// ----------------------------------------------------------------------------
// dual_channel_drive_ramp_limiter_tb
// Self-checking bench for the two-channel drive ramp limiter. A clocked driver
// sends stick command items from a queue and tracks speeds, fine mode and
// registers in its own model of the block. A clocked monitor compares each
// drive result with the oldest expected one. Phases change the registers
// between drained runs. Both sides idle at random, and one phase holds the
// result side off long enough for the input to stall.
// ----------------------------------------------------------------------------
module dual_channel_drive_ramp_limiter_tb;

    localparam int NUM_PHASES     = 7;
    localparam int ITEMS_PER_PHASE = 118;
    localparam int LONG_HOLD      = 300;

    typedef struct {
        dcrl_pkg::op_t    op;
        dcrl_pkg::q15_t   first;
        dcrl_pkg::q15_t   second;
        logic [15:0]      elapsed;
        logic             back;
    } stick_cmd_t;

    typedef struct {
        dcrl_pkg::q15_t first_drive;
        dcrl_pkg::q15_t second_drive;
        logic           fine;
    } drive_out_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [dcrl_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [dcrl_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_we = 1'b0;
    logic [dcrl_pkg::IDX_W-1:0]      cfg_index = '0;
    logic [dcrl_pkg::REG_W-1:0]      cfg_data = '0;

    dual_channel_drive_ramp_limiter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // model of the block
    int  dead_band_cfg  = dcrl_pkg::DEAD_BAND_RST;
    int  match_band_cfg = dcrl_pkg::MATCH_BAND_RST;
    int  ramp_cfg       = dcrl_pkg::RAMP_PER_MS_RST;
    int  max_step_cfg   = dcrl_pkg::MAX_STEP_RST;
    int  left_spd, right_spd, move_spd, rotate_spd;
    bit  fine_on;

    stick_cmd_t pending_cmds[$];
    drive_out_t expected_drives[$];
    stick_cmd_t offered;
    bit         offer_open;
    bit         idling_on;
    bit         rx_long_hold_req;
    int         tx_gap_left;
    int         rx_hold_left;
    int         fail_count;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic dcrl_pkg::q15_t drive_neg(int v);
        // -32768 saturates instead of wrapping
        return (v == -32768) ? dcrl_pkg::q15_t'(32767) : dcrl_pkg::q15_t'(-v);
    endfunction

    function automatic int ramp_lane(int stick, int speed, int step);
        int     tgt;
        longint s;
        tgt = stick;
        if (fine_on) tgt = tgt / 2;  // truncates toward zero
        if ((tgt < 0 ? -tgt : tgt) < dead_band_cfg) tgt = 0;
        if (tgt < speed) begin
            s = longint'(speed) - step;
            if (s < tgt) s = tgt;
        end else begin
            s = longint'(speed) + step;
            if (s > tgt) s = tgt;
        end
        return int'(s);
    endfunction

    task automatic advance_speeds(stick_cmd_t c);
        int         first;
        int         second;
        int         diff;
        int         step;
        longint     prod;
        drive_out_t d;
        first  = c.first;
        second = c.second;
        if (c.back) fine_on = !fine_on;
        prod = longint'(c.elapsed) * ramp_cfg;
        step = (prod > max_step_cfg) ? max_step_cfg : int'(prod);
        if (c.op == dcrl_pkg::OP_TANK) begin
            diff = first - second;
            if ((diff < 0 ? -diff : diff) < match_band_cfg) first = second;
            left_spd  = ramp_lane(first, left_spd, step);
            right_spd = ramp_lane(second, right_spd, step);
            d.first_drive  = drive_neg(left_spd);
            d.second_drive = drive_neg(right_spd);
        end else begin
            move_spd   = ramp_lane(first, move_spd, step);
            rotate_spd = ramp_lane(second, rotate_spd, step);
            d.first_drive  = drive_neg(move_spd);
            d.second_drive = dcrl_pkg::q15_t'(rotate_spd);
        end
        d.fine = fine_on;
        expected_drives.push_back(d);
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_speeds(offered);
                offer_open = 1'b0;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    offered    = pending_cmds.pop_front();
                    offer_open = 1'b1;
                    s_tdata  <= {7'd0, offered.back, offered.elapsed,
                                 offered.second, offered.first};
                    s_tuser  <= offered.op;
                    s_tvalid <= 1'b1;
                    if (idling_on && $urandom_range(0, 3) == 0) tx_gap_left = gap_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin : result_check
        drive_out_t     want;
        dcrl_pkg::q15_t got_first;
        dcrl_pkg::q15_t got_second;
        logic           got_fine;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_first  = m_tdata[15:0];
                got_second = m_tdata[31:16];
                got_fine   = m_tdata[32];
                if (expected_drives.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result item: first %0d second %0d fine %0b",
                                 got_first, got_second, got_fine);
                end else begin
                    want = expected_drives.pop_front();
                    if (got_first !== want.first_drive || got_second !== want.second_drive
                        || got_fine !== want.fine) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch at %0t: expected %0d %0d %0b, got %0d %0d %0b",
                                     $realtime, want.first_drive, want.second_drive,
                                     want.fine, got_first, got_second, got_fine);
                    end
                end
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else if (rx_long_hold_req) begin
                rx_long_hold_req = 1'b0;
                rx_hold_left     = LONG_HOLD;
                m_tready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                rx_hold_left = gap_len();
                m_tready <= (rx_hold_left == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic dcrl_pkg::q15_t pick_stick();
        int v;
        case ($urandom_range(0, 5))
            0: v = 32767 - int'($urandom_range(0, 2));
            1: v = -32768 + int'($urandom_range(0, 2));
            2: begin
                v = dead_band_cfg + int'($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 1)) v = -v;
            end
            3: begin
                // lands near the band edge once halved
                v = 2 * dead_band_cfg + int'($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        return dcrl_pkg::q15_t'(v);
    endfunction

    task automatic queue_cmd(dcrl_pkg::op_t op, int first, int second, int elapsed, bit back);
        stick_cmd_t c;
        c.op      = op;
        c.first   = dcrl_pkg::q15_t'(first);
        c.second  = dcrl_pkg::q15_t'(second);
        c.elapsed = 16'(elapsed);
        c.back    = back;
        pending_cmds.push_back(c);
    endtask

    task automatic write_reg(dcrl_pkg::cfg_idx_t idx, dcrl_pkg::cfg_val_t val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            dcrl_pkg::CFG_DEAD_BAND:   dead_band_cfg  = val;
            dcrl_pkg::CFG_MATCH_BAND:  match_band_cfg = val;
            dcrl_pkg::CFG_RAMP_PER_MS: ramp_cfg       = val;
            dcrl_pkg::CFG_MAX_STEP:    max_step_cfg   = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || offer_open || expected_drives.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        dcrl_pkg::cfg_val_t phase_cfg [NUM_PHASES][4];
        stick_cmd_t         cmd;
        int                 delta;
        int                 p;
        int                 i;
        int                 r;

        phase_cfg[0] = '{15'd0, 15'd0, 15'd0, 15'd0};
        phase_cfg[1] = '{15'd32767, 15'd32767, 15'd32767, 15'd32767};
        phase_cfg[2] = '{dcrl_pkg::DEAD_BAND_RST, dcrl_pkg::MATCH_BAND_RST,
                         dcrl_pkg::RAMP_PER_MS_RST, dcrl_pkg::MAX_STEP_RST};
        phase_cfg[3] = '{15'd0, 15'd0, 15'd32767, 15'd32767};
        phase_cfg[4] = '{15'd100, 15'd32767, 15'd1, 15'd500};
        for (r = 0; r < 4; r++) begin
            phase_cfg[5][r] = dcrl_pkg::cfg_val_t'($urandom_range(0, 32767));
            phase_cfg[6][r] = dcrl_pkg::cfg_val_t'($urandom_range(0, 6000));
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part, reset register values
        idling_on = 1'b1;
        queue_cmd(dcrl_pkg::OP_TANK, 32767, -32767, 10, 1'b0);
        queue_cmd(dcrl_pkg::OP_TANK, 32767, -32767, 65535, 1'b0);
        queue_cmd(dcrl_pkg::OP_TANK, -32768, 32767, 65535, 1'b0);
        queue_cmd(dcrl_pkg::OP_TANK, 21000, 20000, 65535, 1'b0);   // sticks matched
        queue_cmd(dcrl_pkg::OP_TANK, 1000, -1000, 65535, 1'b0);
        queue_cmd(dcrl_pkg::OP_TANK, 3277, -3276, 65535, 1'b0);    // dead band edge
        for (i = 0; i < 4; i++)
            queue_cmd(dcrl_pkg::OP_ARCADE, -32768, -32768, 65535, 1'b0);
        queue_cmd(dcrl_pkg::OP_ARCADE, 0, 0, 0, 1'b0);
        queue_cmd(dcrl_pkg::OP_ARCADE, 32767, 32767, 65535, 1'b1);
        queue_cmd(dcrl_pkg::OP_ARCADE, -32767, -7, 3, 1'b0);
        queue_cmd(dcrl_pkg::OP_TANK, -32767, 32767, 65535, 1'b0);
        queue_cmd(dcrl_pkg::OP_TANK, -32768, -32768, 65535, 1'b0); // halved minimum
        queue_cmd(dcrl_pkg::OP_ARCADE, 32767, -32767, 65535, 1'b1);
        queue_cmd(dcrl_pkg::OP_TANK, 0, 0, 1, 1'b1);
        queue_cmd(dcrl_pkg::OP_TANK, 0, 0, 1, 1'b1);
        queue_cmd(dcrl_pkg::OP_ARCADE, 5000, -5000, 65535, 1'b0);
        queue_cmd(dcrl_pkg::OP_TANK, -5, 5, 65535, 1'b0);

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            for (r = 0; r < 4; r++)
                write_reg(dcrl_pkg::cfg_idx_t'(r), phase_cfg[p][r]);
            idling_on = (p != 1 && p != 2);
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                cmd.op    = dcrl_pkg::op_t'($urandom_range(0, 1));
                cmd.first = pick_stick();
                if ($urandom_range(0, 9) < 3) begin
                    delta = match_band_cfg + int'($urandom_range(0, 4)) - 2;
                    if ($urandom_range(0, 1)) delta = -delta;
                    cmd.second = dcrl_pkg::q15_t'(int'(cmd.first) + delta);
                end else begin
                    cmd.second = pick_stick();
                end
                case ($urandom_range(0, 9))
                    0:       cmd.elapsed = '0;
                    1, 2:    cmd.elapsed = 16'($urandom_range(0, 65535));
                    3:       cmd.elapsed = 16'(65535 - $urandom_range(0, 3));
                    default: cmd.elapsed = 16'($urandom_range(1, 40));
                endcase
                cmd.back = ($urandom_range(0, 9) == 0);
                pending_cmds.push_back(cmd);
                if (p == 4 && i == ITEMS_PER_PHASE / 2) begin
                    // sender runs dry until every result is back
                    wait_drained();
                end
            end
            if (p == 2) rx_long_hold_req = 1'b1;
        end

        wait_drained();
        if (fail_count == 0)
            $display("dual_channel_drive_ramp_limiter verification clean");
        else
            $display("dual_channel_drive_ramp_limiter verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("dual_channel_drive_ramp_limiter verification failed");
        $finish;
    end

endmodule
